[sv/ipv4_forward_decision_macros.svh]
// assertion macros shared by the forwarding decision checker
`ifndef IPV4_FORWARD_DECISION_MACROS_SVH
`define IPV4_FORWARD_DECISION_MACROS_SVH

// clocked check, quiet while reset is held
`define FWD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define FWD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/rfd_pkg.sv]
// types, constants and checksum helper for the ipv4 forwarding decision block
package rfd_pkg;

  // stream payload layout
  localparam int IN_TDATA_W  = 248;
  localparam int OUT_TDATA_W = 32;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_IFACE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IFACE_IP0   = 3'd1;

  // header rules
  localparam logic [15:0] MIN_FRAME_LEN = 16'd34;
  localparam logic [7:0]  PROTO_ICMP    = 8'd1;
  localparam logic [3:0]  IP_VERSION    = 4'd4;
  localparam logic [2:0]  IFACE_COUNT_RST = 3'd1;

  typedef enum logic [3:0] {
    ACT_SHORT         = 4'd0,
    ACT_NOT_V4        = 4'd1,
    ACT_BAD_SUM       = 4'd2,
    ACT_LOCAL_ICMP    = 4'd3,
    ACT_PORT_UNREACH  = 4'd4,
    ACT_NET_UNREACH   = 4'd5,
    ACT_TTL_EXCEEDED  = 4'd6,
    ACT_FORWARD       = 4'd7,
    ACT_ROUTE_WRITTEN = 4'd8
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM_A,
    ST_SUM_B,
    ST_CHECK,
    ST_LOOKUP,
    ST_DONE
  } state_t;

  // search token that walks the route cells
  typedef struct packed {
    logic        vld;
    logic [31:0] dst;
    logic        found;
    logic [31:0] mask;
    logic [1:0]  port;
  } lkp_t;

  // route table write bundle
  typedef struct packed {
    logic        en;
    logic [3:0]  index;
    logic [31:0] prefix;
    logic [31:0] mask;
    logic [1:0]  port;
    logic        active;
  } rt_wr_t;

  // end-around carry fold of a nine-word sum, then complement
  function automatic logic [15:0] csum_fold(input logic [19:0] s);
    logic [16:0] f1;
    logic [15:0] f2;
    f1 = {1'b0, s[15:0]} + {13'd0, s[19:16]};
    f2 = f1[15:0] + {15'd0, f1[16]};
    return ~f2;
  endfunction

endpackage

[sv/rfd_route_cell.sv]
// one route table entry with its stage of the longest-prefix search
module rfd_route_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  rfd_pkg::rt_wr_t wr,
  input  logic          wr_sel,
  input  rfd_pkg::lkp_t lkp_in,
  output rfd_pkg::lkp_t lkp_out
);

  logic [31:0]   prefix_r;
  logic [31:0]   mask_r;
  logic [1:0]    port_r;
  logic          active_r;
  rfd_pkg::lkp_t lkp_r;
  rfd_pkg::lkp_t lkp_nxt;
  logic          hit;
  logic          take;

  // entry storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (wr_sel) begin
      active_r <= wr.active;
    end
    if (wr_sel) begin
      prefix_r <= wr.prefix;
      mask_r   <= wr.mask;
      port_r   <= wr.port;
    end
  end

  // match and keep the strictly longer mask, so earlier cells win ties
  always_comb begin
    hit  = active_r && ((prefix_r & mask_r) == (lkp_in.dst & mask_r));
    take = hit && (!lkp_in.found || (mask_r > lkp_in.mask));
    lkp_nxt = lkp_in;
    if (take) begin
      lkp_nxt.found = 1'b1;
      lkp_nxt.mask  = mask_r;
      lkp_nxt.port  = port_r;
    end
  end

  // hand the token to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lkp_r <= '0;
    end else begin
      lkp_r <= lkp_nxt;
    end
  end

  assign lkp_out = lkp_r;

endmodule

[sv/rfd_route_chain.sv]
// row of route cells with write decode; the search token moves one cell per cycle
module rfd_route_chain #(
  parameter int ROUTE_ENTRIES = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  rfd_pkg::rt_wr_t wr,
  input  rfd_pkg::lkp_t   key,
  output rfd_pkg::lkp_t   result
);

  rfd_pkg::lkp_t link [ROUTE_ENTRIES+1];

  assign link[0] = key;

  // one cell per slot, writes to slots past the end select nothing
  for (genvar i = 0; i < ROUTE_ENTRIES; i++) begin : g_cell
    logic sel;
    assign sel = wr.en && (32'(wr.index) == i);
    rfd_route_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr      (wr),
      .wr_sel  (sel),
      .lkp_in  (link[i]),
      .lkp_out (link[i+1])
    );
  end

  assign result = link[ROUTE_ENTRIES];

endmodule

[sv/ipv4_forward_decision.sv]
// ipv4 forwarding decision: header checks, local match and route lookup
//
//  channel  dir  handshake             payload
//  in_      in   in_tvalid/in_tready   in_tuser = func, in_tdata = route and header fields
//  out_     out  out_tvalid/out_tready out_tdata = action and rewrite fields
//  cfg_     in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// one item is worked at a time; a route write passes SUM_A and DONE, a header
// stopped by a check or a local match passes SUM_A, SUM_B, CHECK and DONE, and a routed
// header also waits in LOOKUP while the search walks the row of route cells one per cycle.
// reset is synchronous and active low; it clears the route valid bits and sets
// iface_count to 1. a result waits in the output register while the next item
// is taken; cfg_ready is always high.
module ipv4_forward_decision #(
  parameter int ROUTE_ENTRIES = 16,
  parameter int NUM_IFACES    = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: route_index, route_dest, route_netmask, route_port, route_valid,
  //   frame_len, hdr_bytes_0_7, hdr_bytes_8_15, hdr_bytes_16_19, zero pad bit
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [rfd_pkg::IN_TDATA_W-1:0]     in_tdata,
  // in_tuser: func
  input  logic                               in_tuser,
  // out_tdata: action, egress_port, local_port, new_ttl, new_checksum
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [rfd_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                        cfg_data
);

  // configuration registers
  logic [2:0]  iface_count_r;
  logic [31:0] iface_ip_r [NUM_IFACES];

  // captured item
  logic        func_r;
  logic [3:0]  rt_index_r;
  logic [31:0] rt_dest_r;
  logic [31:0] rt_mask_r;
  logic [1:0]  rt_port_r;
  logic        rt_valid_r;
  logic [15:0] frame_len_r;
  logic [63:0] hdr0_r;
  logic [63:0] hdr1_r;
  logic [31:0] dst_r;

  // control and datapath registers
  rfd_pkg::state_t  state_r, state_nxt;
  logic [17:0]      psum_r, psum_nxt;
  logic [18:0]      base_r, base_nxt;
  logic [15:0]      new_csum_r, new_csum_nxt;
  rfd_pkg::action_t res_action_r, res_action_nxt;
  logic [1:0]       res_egress_r, res_egress_nxt;
  logic [1:0]       res_local_r, res_local_nxt;
  logic [7:0]       res_ttl_r, res_ttl_nxt;
  logic [15:0]      res_csum_r, res_csum_nxt;
  logic             out_valid_r, out_valid_nxt;
  rfd_pkg::action_t out_action_r, out_action_nxt;
  logic [1:0]       out_egress_r, out_egress_nxt;
  logic [1:0]       out_local_r, out_local_nxt;
  logic [7:0]       out_ttl_r, out_ttl_nxt;
  logic [15:0]      out_csum_r, out_csum_nxt;

  logic [15:0]     w [10];
  logic [7:0]      ttl;
  logic [7:0]      proto;
  logic [15:0]     w4_new;
  logic [15:0]     sum_old;
  logic [15:0]     sum_new;
  logic            local_hit;
  logic [1:0]      local_idx;
  logic            in_xfer;
  rfd_pkg::rt_wr_t rt_wr;
  rfd_pkg::lkp_t   lkp_key;
  rfd_pkg::lkp_t   lkp_res;

  assign in_xfer   = in_tvalid && in_tready;
  assign in_tready = (state_r == rfd_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iface_count_r <= rfd_pkg::IFACE_COUNT_RST;
      for (int i = 0; i < NUM_IFACES; i++) begin
        iface_ip_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == rfd_pkg::CFG_IFACE_COUNT) begin
        iface_count_r <= cfg_data[2:0];
      end
      for (int i = 0; i < NUM_IFACES; i++) begin
        if (cfg_index == (rfd_pkg::CFG_IFACE_IP0 + rfd_pkg::CFG_IDX_W'(i))) begin
          iface_ip_r[i] <= cfg_data;
        end
      end
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      func_r      <= in_tuser;
      rt_index_r  <= in_tdata[3:0];
      rt_dest_r   <= in_tdata[35:4];
      rt_mask_r   <= in_tdata[67:36];
      rt_port_r   <= in_tdata[69:68];
      rt_valid_r  <= in_tdata[70];
      frame_len_r <= in_tdata[86:71];
      hdr0_r      <= in_tdata[150:87];
      hdr1_r      <= in_tdata[214:151];
      dst_r       <= in_tdata[246:215];
    end
  end

  // header words, word 0 first
  assign w[0] = hdr0_r[63:48];
  assign w[1] = hdr0_r[47:32];
  assign w[2] = hdr0_r[31:16];
  assign w[3] = hdr0_r[15:0];
  assign w[4] = hdr1_r[63:48];
  assign w[5] = hdr1_r[47:32];
  assign w[6] = hdr1_r[31:16];
  assign w[7] = hdr1_r[15:0];
  assign w[8] = dst_r[31:16];
  assign w[9] = dst_r[15:0];

  assign ttl     = hdr1_r[63:56];
  assign proto   = hdr1_r[55:48];
  assign w4_new  = {ttl - 8'd1, proto};
  assign sum_old = rfd_pkg::csum_fold(20'(base_r) + 20'(w[4]));
  assign sum_new = rfd_pkg::csum_fold(20'(base_r) + 20'(w4_new));

  // first interface in use whose address equals the destination
  always_comb begin
    local_hit = 1'b0;
    local_idx = '0;
    for (int i = NUM_IFACES - 1; i >= 0; i--) begin
      if ((3'(i) < iface_count_r) && (iface_ip_r[i] == dst_r)) begin
        local_hit = 1'b1;
        local_idx = 2'(i);
      end
    end
  end

  // route write from the captured item
  always_comb begin
    rt_wr.en     = (state_r == rfd_pkg::ST_SUM_A) && !func_r;
    rt_wr.index  = rt_index_r;
    rt_wr.prefix = rt_dest_r;
    rt_wr.mask   = rt_mask_r;
    rt_wr.port   = rt_port_r;
    rt_wr.active = rt_valid_r;
  end

  rfd_route_chain #(
    .ROUTE_ENTRIES (ROUTE_ENTRIES)
  ) u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (rt_wr),
    .key    (lkp_key),
    .result (lkp_res)
  );

  // sequencer: next state, datapath and result
  always_comb begin
    state_nxt      = state_r;
    psum_nxt       = psum_r;
    base_nxt       = base_r;
    new_csum_nxt   = new_csum_r;
    res_action_nxt = res_action_r;
    res_egress_nxt = res_egress_r;
    res_local_nxt  = res_local_r;
    res_ttl_nxt    = res_ttl_r;
    res_csum_nxt   = res_csum_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_action_nxt = out_action_r;
    out_egress_nxt = out_egress_r;
    out_local_nxt  = out_local_r;
    out_ttl_nxt    = out_ttl_r;
    out_csum_nxt   = out_csum_r;
    lkp_key.vld    = 1'b0;
    lkp_key.dst    = dst_r;
    lkp_key.found  = 1'b0;
    lkp_key.mask   = '0;
    lkp_key.port   = '0;

    case (state_r)
      rfd_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = rfd_pkg::ST_SUM_A;
        end
      end
      rfd_pkg::ST_SUM_A: begin
        res_egress_nxt = '0;
        res_local_nxt  = '0;
        res_ttl_nxt    = '0;
        res_csum_nxt   = '0;
        if (!func_r) begin
          res_action_nxt = rfd_pkg::ACT_ROUTE_WRITTEN;
          state_nxt      = rfd_pkg::ST_DONE;
        end else begin
          psum_nxt  = 18'(w[0]) + 18'(w[1]) + 18'(w[2]) + 18'(w[3]);
          state_nxt = rfd_pkg::ST_SUM_B;
        end
      end
      rfd_pkg::ST_SUM_B: begin
        base_nxt  = 19'(psum_r) + 19'(w[6]) + 19'(w[7]) + 19'(w[8]) + 19'(w[9]);
        state_nxt = rfd_pkg::ST_CHECK;
      end
      rfd_pkg::ST_CHECK: begin
        state_nxt = rfd_pkg::ST_DONE;
        if (frame_len_r < rfd_pkg::MIN_FRAME_LEN) begin
          res_action_nxt = rfd_pkg::ACT_SHORT;
        end else if (hdr0_r[63:60] != rfd_pkg::IP_VERSION) begin
          res_action_nxt = rfd_pkg::ACT_NOT_V4;
        end else if (sum_old != w[5]) begin
          res_action_nxt = rfd_pkg::ACT_BAD_SUM;
        end else if (local_hit) begin
          res_action_nxt = (proto == rfd_pkg::PROTO_ICMP) ? rfd_pkg::ACT_LOCAL_ICMP
                                                          : rfd_pkg::ACT_PORT_UNREACH;
          res_local_nxt  = local_idx;
        end else begin
          lkp_key.vld  = 1'b1;
          new_csum_nxt = sum_new;
          state_nxt    = rfd_pkg::ST_LOOKUP;
        end
      end
      rfd_pkg::ST_LOOKUP: begin
        if (lkp_res.vld) begin
          state_nxt = rfd_pkg::ST_DONE;
          if (!lkp_res.found) begin
            res_action_nxt = rfd_pkg::ACT_NET_UNREACH;
          end else begin
            res_egress_nxt = lkp_res.port;
            if (ttl <= 8'd1) begin
              res_action_nxt = rfd_pkg::ACT_TTL_EXCEEDED;
            end else begin
              res_action_nxt = rfd_pkg::ACT_FORWARD;
              res_ttl_nxt    = ttl - 8'd1;
              res_csum_nxt   = new_csum_r;
            end
          end
        end
      end
      rfd_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_action_nxt = res_action_r;
          out_egress_nxt = res_egress_r;
          out_local_nxt  = res_local_r;
          out_ttl_nxt    = res_ttl_r;
          out_csum_nxt   = res_csum_r;
          state_nxt      = rfd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rfd_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rfd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    psum_r       <= psum_nxt;
    base_r       <= base_nxt;
    new_csum_r   <= new_csum_nxt;
    res_action_r <= res_action_nxt;
    res_egress_r <= res_egress_nxt;
    res_local_r  <= res_local_nxt;
    res_ttl_r    <= res_ttl_nxt;
    res_csum_r   <= res_csum_nxt;
    out_action_r <= out_action_nxt;
    out_egress_r <= out_egress_nxt;
    out_local_r  <= out_local_nxt;
    out_ttl_r    <= out_ttl_nxt;
    out_csum_r   <= out_csum_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_csum_r, out_ttl_r, out_local_r, out_egress_r, out_action_r};

endmodule

[sv/rfd_checker.sv]
// port-level checks for the forwarding decision block and their binding
`include "ipv4_forward_decision_macros.svh"

module rfd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [rfd_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // a held result keeps its value
  `FWD_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")

  // one item at a time: taking an item closes the input
  `FWD_ASSERT(a_one_item, in_tvalid && in_tready |=> !in_tready, "second item taken while one is in flight")

  // action code stays within the defined set
  `FWD_ASSERT(a_action_range, out_tvalid |-> out_tdata[3:0] <= rfd_pkg::ACT_ROUTE_WRITTEN, "undefined action code")

  // rewrite fields are zero unless the header is forwarded
  `FWD_ASSERT(a_rewrite_zero, out_tvalid && out_tdata[3:0] != rfd_pkg::ACT_FORWARD |-> out_tdata[31:8] == 24'd0, "rewrite fields set without forward")

  // forwarded ttl is never zero
  `FWD_ASSERT_ALWAYS(a_fwd_ttl, rst_n && out_tvalid && out_tdata[3:0] == rfd_pkg::ACT_FORWARD |-> out_tdata[15:8] != 8'd0, "forward with zero ttl")

endmodule

bind ipv4_forward_decision rfd_checker u_rfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[verif/ipv4_forward_decision_tb.sv]
// self-checking testbench for the ipv4 forwarding decision block
`timescale 1ns / 1ps

module ipv4_forward_decision_tb;

  localparam int ROUTE_SLOTS = 16;
  localparam int IFACES      = 4;

  // one input transaction, unpacked
  typedef struct {
    bit        func;
    bit [3:0]  route_index;
    bit [31:0] route_dest;
    bit [31:0] route_netmask;
    bit [1:0]  route_port;
    bit        route_valid;
    bit [15:0] frame_len;
    bit [63:0] hdr_a;      // header bytes 0..7
    bit [63:0] hdr_b;      // header bytes 8..15
    bit [31:0] dst_addr;   // header bytes 16..19
  } fwd_item_t;

  // one decision, unpacked
  typedef struct {
    rfd_pkg::action_t action;
    bit [1:0]         egress_port;
    bit [1:0]         local_port;
    bit [7:0]         new_ttl;
    bit [15:0]        new_checksum;
  } fwd_result_t;

  // predicts each forwarding decision and checks the block against it
  class decision_scoreboard;
    bit [2:0]    iface_count;
    bit [31:0]   iface_ip [IFACES];
    bit [31:0]   route_prefix [ROUTE_SLOTS];
    bit [31:0]   route_mask [ROUTE_SLOTS];
    bit [1:0]    route_port [ROUTE_SLOTS];
    bit          route_active [ROUTE_SLOTS];
    fwd_result_t pending_decisions [$];
    int          mismatches;
    int          results_checked;
    int          route_writes;
    int          action_seen [9];

    function new();
      iface_count = rfd_pkg::IFACE_COUNT_RST;
      foreach (iface_ip[i]) iface_ip[i] = '0;
      foreach (route_active[i]) begin
        route_prefix[i] = '0;
        route_mask[i]   = '0;
        route_port[i]   = '0;
        route_active[i] = 1'b0;
      end
    endfunction

    // ones' complement sum of the nine words other than the checksum, complemented
    static function bit [15:0] header_csum(bit [63:0] a, bit [63:0] b, bit [31:0] d);
      bit [31:0] sum;
      sum = a[63:48] + a[47:32] + a[31:16] + a[15:0] + b[63:48] + b[31:16] + b[15:0]
            + d[31:16] + d[15:0];
      sum = sum[31:16] + sum[15:0];
      sum = sum[31:16] + sum[15:0];
      return ~sum[15:0];
    endfunction

    function void note_config(bit [2:0] idx, bit [31:0] data);
      if (idx == rfd_pkg::CFG_IFACE_COUNT)
        iface_count = data[2:0];
      else if (idx >= rfd_pkg::CFG_IFACE_IP0 && idx <= rfd_pkg::CFG_IFACE_IP0 + 3'd3)
        iface_ip[idx - rfd_pkg::CFG_IFACE_IP0] = data;
    endfunction

    // work out the decision for an accepted transaction and queue it
    function void note_item(fwd_item_t it);
      fwd_result_t r;
      bit [7:0]    ttl;
      bit [7:0]    proto;
      int          n;
      int          best;
      bit          hit;
      r.action       = rfd_pkg::ACT_SHORT;
      r.egress_port  = '0;
      r.local_port   = '0;
      r.new_ttl      = '0;
      r.new_checksum = '0;
      ttl   = it.hdr_b[63:56];
      proto = it.hdr_b[55:48];
      if (!it.func) begin
        route_prefix[it.route_index] = it.route_dest;
        route_mask[it.route_index]   = it.route_netmask;
        route_port[it.route_index]   = it.route_port;
        route_active[it.route_index] = it.route_valid;
        r.action = rfd_pkg::ACT_ROUTE_WRITTEN;
        route_writes++;
      end else if (it.frame_len < rfd_pkg::MIN_FRAME_LEN) begin
        r.action = rfd_pkg::ACT_SHORT;
      end else if (it.hdr_a[63:60] != rfd_pkg::IP_VERSION) begin
        r.action = rfd_pkg::ACT_NOT_V4;
      end else if (header_csum(it.hdr_a, it.hdr_b, it.dst_addr) != it.hdr_b[47:32]) begin
        r.action = rfd_pkg::ACT_BAD_SUM;
      end else begin
        // first interface address that equals the destination wins
        n = (iface_count > IFACES) ? IFACES : iface_count;
        hit = 1'b0;
        for (int i = 0; i < n && !hit; i++) begin
          if (iface_ip[i] == it.dst_addr) begin
            hit = 1'b1;
            r.action = (proto == rfd_pkg::PROTO_ICMP) ? rfd_pkg::ACT_LOCAL_ICMP
                                                      : rfd_pkg::ACT_PORT_UNREACH;
            r.local_port = i[1:0];
          end
        end
        if (!hit) begin
          // longest prefix, strictly larger mask replaces, ties keep lowest slot
          best = -1;
          for (int i = 0; i < ROUTE_SLOTS; i++) begin
            if (route_active[i] &&
                (route_prefix[i] & route_mask[i]) == (it.dst_addr & route_mask[i]) &&
                (best < 0 || route_mask[i] > route_mask[best]))
              best = i;
          end
          if (best < 0) begin
            r.action = rfd_pkg::ACT_NET_UNREACH;
          end else begin
            r.egress_port = route_port[best];
            if (ttl <= 8'd1) begin
              r.action = rfd_pkg::ACT_TTL_EXCEEDED;
            end else begin
              r.action       = rfd_pkg::ACT_FORWARD;
              r.new_ttl      = ttl - 8'd1;
              r.new_checksum = header_csum(it.hdr_a, {ttl - 8'd1, proto, it.hdr_b[47:0]},
                                           it.dst_addr);
            end
          end
        end
      end
      pending_decisions.push_back(r);
    endfunction

    // compare one result transaction with the oldest pending decision
    function void check_result(bit [rfd_pkg::OUT_TDATA_W-1:0] d);
      fwd_result_t want;
      fwd_result_t got;
      got.action       = rfd_pkg::action_t'(d[3:0]);
      got.egress_port  = d[5:4];
      got.local_port   = d[7:6];
      got.new_ttl      = d[15:8];
      got.new_checksum = d[31:16];
      if (pending_decisions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result %h with no decision pending", $realtime, d);
        return;
      end
      want = pending_decisions.pop_front();
      results_checked++;
      if (d[3:0] <= rfd_pkg::ACT_ROUTE_WRITTEN) action_seen[d[3:0]]++;
      if (got.action != want.action || got.egress_port != want.egress_port ||
          got.local_port != want.local_port || got.new_ttl != want.new_ttl ||
          got.new_checksum != want.new_checksum) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"[%0t] mismatch: expected act=%0d egr=%0d loc=%0d ttl=%0d sum=%h,",
                    " got act=%0d egr=%0d loc=%0d ttl=%0d sum=%h"},
                   $realtime, want.action, want.egress_port, want.local_port, want.new_ttl,
                   want.new_checksum, got.action, got.egress_port, got.local_port,
                   got.new_ttl, got.new_checksum);
      end
    endfunction
  endclass

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [rfd_pkg::IN_TDATA_W-1:0]   in_tdata;
  logic                             in_tuser;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [rfd_pkg::OUT_TDATA_W-1:0]  out_tdata;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [rfd_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [31:0]                      cfg_data;

  decision_scoreboard sb = new();

  bit offering;
  int burst_left;
  int items_sent;
  bit long_hold_req;

  ipv4_forward_decision #(
    .ROUTE_ENTRIES(ROUTE_SLOTS),
    .NUM_IFACES   (IFACES)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("ipv4_forward_decision_tb: FAIL");
    $finish;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata);
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(50, 300);
        end
        mode_left--;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= ~out_tready;
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic logic [rfd_pkg::IN_TDATA_W-1:0] pack_item(fwd_item_t it);
    return {1'b0, it.dst_addr, it.hdr_b, it.hdr_a, it.frame_len, it.route_valid,
            it.route_port, it.route_netmask, it.route_dest, it.route_index};
  endfunction

  function automatic bit [31:0] prefix_mask(int len);
    return (len == 0) ? 32'h0 : 32'hFFFF_FFFF << (32 - len);
  endfunction

  // every field random, including the ones the operation does not use
  function automatic fwd_item_t noise_item();
    fwd_item_t it;
    it.func          = 1'($urandom_range(0, 1));
    it.route_index   = 4'($urandom_range(0, 15));
    it.route_dest    = $urandom;
    it.route_netmask = $urandom;
    it.route_port    = 2'($urandom_range(0, 3));
    it.route_valid   = 1'($urandom_range(0, 1));
    it.frame_len     = 16'($urandom_range(0, 65535));
    it.hdr_a         = {$urandom, $urandom};
    it.hdr_b         = {$urandom, $urandom};
    it.dst_addr      = $urandom;
    return it;
  endfunction

  function automatic fwd_item_t route_item(bit [3:0] idx, bit [31:0] dest, bit [31:0] mask,
                                           bit [1:0] port, bit valid);
    fwd_item_t it;
    it = noise_item();
    it.func          = 1'b0;
    it.route_index   = idx;
    it.route_dest    = dest;
    it.route_netmask = mask;
    it.route_port    = port;
    it.route_valid   = valid;
    return it;
  endfunction

  function automatic fwd_item_t make_header(bit [3:0] ver, bit [31:0] dst, bit [7:0] ttl,
                                            bit [7:0] proto, bit good_sum, bit [15:0] flen);
    fwd_item_t it;
    bit [15:0] csum;
    it = noise_item();
    it.func          = 1'b1;
    it.frame_len     = flen;
    it.hdr_a[63:60]  = ver;
    it.hdr_b[63:56]  = ttl;
    it.hdr_b[55:48]  = proto;
    it.dst_addr      = dst;
    csum = decision_scoreboard::header_csum(it.hdr_a, it.hdr_b, dst);
    it.hdr_b[47:32]  = good_sum ? csum : csum ^ 16'($urandom_range(1, 65535));
    return it;
  endfunction

  function automatic bit [15:0] rand_frame_len();
    case ($urandom_range(0, 9))
      0: return rfd_pkg::MIN_FRAME_LEN;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(34, 65535));
      default: return 16'($urandom_range(34, 1518));
    endcase
  endfunction

  function automatic bit [7:0] rand_ttl();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd2;
      3: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic bit [7:0] rand_proto();
    return ($urandom_range(0, 4) < 2) ? rfd_pkg::PROTO_ICMP : 8'($urandom_range(0, 255));
  endfunction

  function automatic bit [31:0] rand_ip();
    case ($urandom_range(0, 4))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic fwd_item_t good_header(bit [31:0] dst, bit [7:0] ttl, bit [7:0] proto);
    return make_header(rfd_pkg::IP_VERSION, dst, ttl, proto, 1'b1, rand_frame_len());
  endfunction

  // mostly well-formed headers aimed at interfaces and routes, some route updates and noise
  function automatic fwd_item_t random_item();
    int        pick;
    int        slot;
    int        len;
    bit [31:0] dst;
    bit [31:0] m;
    bit [3:0]  ver;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      case ($urandom_range(0, 4))
        0: len = 0;
        1: len = 32;
        default: len = $urandom_range(0, 32);
      endcase
      m = ($urandom_range(0, 9) == 0) ? $urandom : prefix_mask(len);
      return route_item(4'($urandom_range(0, 15)), $urandom, m, 2'($urandom_range(0, 3)),
                        $urandom_range(0, 4) != 0);
    end
    if (pick < 15)
      return noise_item();
    case ($urandom_range(0, 3))
      0: dst = sb.iface_ip[$urandom_range(0, IFACES - 1)];
      1, 2: begin
        slot = $urandom_range(0, ROUTE_SLOTS - 1);
        m = sb.route_mask[slot];
        dst = (sb.route_prefix[slot] & m) | ($urandom & ~m);
      end
      default: dst = $urandom;
    endcase
    if (pick < 19)
      return make_header(rfd_pkg::IP_VERSION, dst, rand_ttl(), rand_proto(), 1'b1,
                         16'($urandom_range(0, 33)));
    if (pick < 23) begin
      ver = 4'($urandom_range(0, 15));
      if (ver == rfd_pkg::IP_VERSION) ver = 4'd6;
      return make_header(ver, dst, rand_ttl(), rand_proto(), 1'b1, rand_frame_len());
    end
    if (pick < 28)
      return make_header(rfd_pkg::IP_VERSION, dst, rand_ttl(), rand_proto(), 1'b0,
                         rand_frame_len());
    return good_header(dst, rand_ttl(), rand_proto());
  endfunction

  // offer one transaction, in bursts with random gaps between them
  task automatic send_item(input fwd_item_t it);
    int gap;
    if (burst_left == 0) begin
      if (offering) in_tvalid <= 1'b0;
      offering = 1'b0;
      gap = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                               : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.func;
    in_tdata  <= pack_item(it);
    offering = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(it);
    burst_left--;
    items_sent++;
  endtask

  // stop offering and wait for every pending decision
  task automatic drain();
    if (offering) in_tvalid <= 1'b0;
    offering = 1'b0;
    burst_left = 0;
    while (sb.pending_decisions.size() != 0) @(posedge clk);
  endtask

  // cfg_valid stays high across back-to-back writes
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.note_config(idx, data);
  endtask

  task automatic configure(input bit [2:0] count, input bit [31:0] ips [IFACES]);
    for (int i = 0; i < IFACES; i++)
      write_reg(rfd_pkg::CFG_IFACE_IP0 + 3'(i), ips[i]);
    write_reg(rfd_pkg::CFG_IFACE_COUNT, {29'd0, count});
    cfg_valid <= 1'b0;
  endtask

  // stimulus
  initial begin
    bit [31:0] ips [IFACES];
    bit [2:0]  phase_count [6];
    string     seen;
    phase_count = '{3'd4, 3'd0, 3'd7, 3'd2, 3'd5, 3'd1};
    offering = 1'b0;
    burst_left = 0;
    items_sent = 0;
    long_hold_req = 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: one interface at 0.0.0.0 and an empty route table
    send_item(good_header(32'h0, 8'd64, rfd_pkg::PROTO_ICMP));
    send_item(good_header(32'h0808_0808, 8'd64, 8'd6));
    drain();

    // directed: route table with default, tie and longer prefixes
    configure(3'd4, '{32'hC0A8_0001, 32'h0A00_0001, 32'h0, 32'hFFFF_FFFF});
    send_item(route_item(4'd0, 32'h1234_5678, 32'h0, 2'd1, 1'b1));
    send_item(route_item(4'd5, 32'h0A01_0000, prefix_mask(16), 2'd2, 1'b1));
    send_item(route_item(4'd6, 32'h0A01_FFFF, prefix_mask(16), 2'd0, 1'b1));
    send_item(route_item(4'd7, 32'h0A01_0200, prefix_mask(24), 2'd3, 1'b1));
    send_item(route_item(4'd15, 32'hC0A8_0002, prefix_mask(32), 2'd3, 1'b1));
    // length, version and checksum checks
    send_item(make_header(rfd_pkg::IP_VERSION, 32'h0A01_0205, 8'd64, 8'd6, 1'b1, 16'd0));
    send_item(make_header(rfd_pkg::IP_VERSION, 32'h0A01_0205, 8'd64, 8'd6, 1'b1, 16'd33));
    send_item(make_header(rfd_pkg::IP_VERSION, 32'h0A01_0205, 8'd64, 8'd6, 1'b1,
                          rfd_pkg::MIN_FRAME_LEN));
    send_item(make_header(rfd_pkg::IP_VERSION, 32'h0A01_0909, 8'd255, 8'd17, 1'b1,
                          16'hFFFF));
    send_item(make_header(4'd6, 32'h0A01_0205, 8'd64, 8'd6, 1'b1, 16'd60));
    send_item(make_header(4'd0, 32'h0A01_0205, 8'd64, 8'd6, 1'b1, 16'd60));
    send_item(make_header(4'hF, 32'h0A01_0205, 8'd64, 8'd6, 1'b1, 16'd60));
    send_item(make_header(rfd_pkg::IP_VERSION, 32'h0A01_0205, 8'd64, 8'd6, 1'b0, 16'd60));
    // local interface matches
    send_item(good_header(32'hC0A8_0001, 8'd64, rfd_pkg::PROTO_ICMP));
    send_item(good_header(32'h0A00_0001, 8'd64, 8'd17));
    send_item(good_header(32'hFFFF_FFFF, 8'd64, rfd_pkg::PROTO_ICMP));
    send_item(good_header(32'h0, 8'd0, 8'd6));
    // ttl edges on a host route
    send_item(good_header(32'hC0A8_0002, 8'd0, 8'd6));
    send_item(good_header(32'hC0A8_0002, 8'd1, 8'd6));
    send_item(good_header(32'hC0A8_0002, 8'd2, 8'd6));
    // clear the default route, then miss
    send_item(route_item(4'd0, 32'h0, 32'h0, 2'd0, 1'b0));
    send_item(good_header(32'h7F00_0001, 8'd64, 8'd6));

    // random phases, each under its own interface setting
    for (int phase = 0; phase < 6; phase++) begin
      drain();
      for (int i = 0; i < IFACES; i++) ips[i] = rand_ip();
      if ($urandom_range(0, 2) == 0) ips[2] = ips[0];
      configure(phase_count[phase], ips);
      for (int k = 0; k < 122; k++) begin
        if (phase == 2 && k == 20) long_hold_req = 1'b1;
        send_item(random_item());
      end
    end

    drain();
    repeat (30) @(posedge clk);
    seen = "";
    foreach (sb.action_seen[a]) seen = {seen, $sformatf(" %0d:%0d", a, sb.action_seen[a])};
    $display("sent %0d transactions (%0d route writes), checked %0d decisions, %0d mismatches",
             items_sent, sb.route_writes, sb.results_checked, sb.mismatches);
    $display("decisions by action:%s; six interface settings, one long output hold-off",
             seen);
    if (sb.mismatches == 0 && sb.pending_decisions.size() == 0)
      $display("ipv4_forward_decision_tb: PASS");
    else
      $display("ipv4_forward_decision_tb: FAIL");
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/rfd_pkg.sv
sv/rfd_route_cell.sv
sv/rfd_route_chain.sv
sv/ipv4_forward_decision.sv
sv/rfd_checker.sv
verif/ipv4_forward_decision_tb.sv
